// ===== rtl/umm_pkg.sv =====
// Package for the serial monitor bus bridge: word types, command and action codes,
// the decoded job record passed from the parser to the result sequencer.
// No dependencies.
package umm_pkg;

  typedef struct packed {
    logic        func;
    logic [7:0]  rx_byte;
    logic [15:0] read_data;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  tx_byte;
    logic [31:0] bus_address;
    logic [15:0] bus_data;
    logic        halfword;
    logic        led_on;
    logic        last;
  } out_word_t;

  // Input kinds
  localparam logic FUNC_RX    = 1'b0;
  localparam logic FUNC_RDATA = 1'b1;

  // Command codes
  localparam logic [7:0] CMD_BAUD        = 8'd0;
  localparam logic [7:0] CMD_LOAD_ADDR   = 8'd1;
  localparam logic [7:0] CMD_READ        = 8'd2;
  localparam logic [7:0] CMD_WRITE       = 8'd3;
  localparam logic [7:0] CMD_BURST_READ  = 8'd4;
  localparam logic [7:0] CMD_BURST_WRITE = 8'd5;
  localparam logic [7:0] CMD_FLASH       = 8'd6;
  localparam logic [7:0] CMD_BURST_FLASH = 8'd7;
  localparam logic [7:0] CMD_HW_READ     = 8'd8;
  localparam logic [7:0] CMD_HW_WRITE    = 8'd9;
  localparam logic [7:0] CMD_EXEC        = 8'd10;
  localparam logic [7:0] CMD_VERSION     = 8'd11;

  localparam logic [7:0] VERSION_ID = 8'd1;

  // Result actions
  localparam logic [2:0] ACT_TX    = 3'd0;
  localparam logic [2:0] ACT_READ  = 3'd1;
  localparam logic [2:0] ACT_WRITE = 3'd2;
  localparam logic [2:0] ACT_BAUD  = 3'd3;
  localparam logic [2:0] ACT_EXEC  = 3'd4;

  // Parse phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_OPER  = 2'd1;
  localparam logic [1:0] PH_RDATA = 2'd2;

  localparam int         BURST_LENGTH    = 16;
  localparam logic [4:0] BURST_LEN       = 5'(BURST_LENGTH);
  localparam int         FLASH_ALIGN_BITS = 19;
  localparam logic [31:0] FLASH_MASK     = ~((32'd1 << FLASH_ALIGN_BITS) - 32'd1);

  localparam logic [31:0] FLASH_ADDR_A = 32'h0000_5555;
  localparam logic [31:0] FLASH_ADDR_B = 32'h0000_2AAA;
  localparam logic [15:0] FLASH_DATA_1 = 16'h00AA;
  localparam logic [15:0] FLASH_DATA_2 = 16'h0055;
  localparam logic [15:0] FLASH_DATA_3 = 16'h00A0;

  // Job kinds
  localparam logic [2:0] JOB_TX     = 3'd0;  // tx
  localparam logic [2:0] JOB_TX2    = 3'd1;  // tx, tx code
  localparam logic [2:0] JOB_READ   = 3'd2;  // read
  localparam logic [2:0] JOB_TXREAD = 3'd3;  // tx, read
  localparam logic [2:0] JOB_WRITE  = 3'd4;  // write, echo?
  localparam logic [2:0] JOB_BAUD   = 3'd5;  // echo, baud
  localparam logic [2:0] JOB_EXEC   = 3'd6;  // exec, echo
  localparam logic [2:0] JOB_FLASH  = 3'd7;  // 3 unlock writes, write, echo?

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tx;
    logic [7:0]  code;
    logic [31:0] addr;
    logic [15:0] data;
    logic        hw;
    logic        echo;
    logic        led;
    logic [31:0] fbase;
  } job_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage

// ===== rtl/uart_memory_monitor_bridge.sv =====
// Serial monitor bus bridge top level: parser, job queue and result sequencer.
// Depends on umm_pkg, umm_front, umm_job_fifo, umm_back.
// Each job passes the queue registers and then the registered output stage before its first result word is valid.
// Throughput: one input word per cycle while the four-entry job queue has room; the
// sequencer delivers one result word per cycle while the output is not stalled, 0 to 5 per input word.
// Reset: synchronous; clears parse state, pointers, LED, queue and output valid.
module uart_memory_monitor_bridge (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  umm_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output umm_pkg::out_word_t out_word
);
  import umm_pkg::*;

  job_t      push_job;
  job_t      head;
  logic      push;
  logic      pop;
  q_status_t q_status;

  umm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_status (q_status),
    .push     (push),
    .job      (push_job)
  );

  umm_job_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  umm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ===== rtl/umm_front.sv =====
// Command parser: accepts input words, keeps the monitor state and turns each word
// into at most one job for the result sequencer. Depends on umm_pkg.
module umm_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  umm_pkg::in_word_t  in_word,
  input  umm_pkg::q_status_t q_status,
  output logic               push,
  output umm_pkg::job_t      job
);
  import umm_pkg::*;

  logic [1:0]  phase, phase_next;
  logic [7:0]  cmd, cmd_next;
  logic [4:0]  cnt, cnt_next;
  logic [23:0] shift, shift_next;
  logic [31:0] ptr, ptr_next;
  logic [31:0] fbase, fbase_next;
  logic        led, led_next;
  logic        accept;
  logic        emit;
  logic        done;
  logic [4:0]  cnt_inc;
  logic [7:0]  b;
  logic [15:0] d;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign b        = in_word.rx_byte;
  assign d        = in_word.read_data;
  assign cnt_inc  = 5'(cnt + 5'd1);

  always_comb begin
    phase_next = phase;
    cmd_next   = cmd;
    cnt_next   = cnt;
    shift_next = shift;
    ptr_next   = ptr;
    fbase_next = fbase;
    led_next   = led;
    emit       = 1'b0;
    done       = 1'b1;
    job        = '0;
    job.addr   = ptr;
    job.fbase  = fbase;
    job.code   = cmd;

    if (in_word.func == FUNC_RX && phase == PH_IDLE) begin
      cmd_next   = b;
      cnt_next   = '0;
      shift_next = '0;
      phase_next = PH_IDLE;
      job.code   = b;
      unique case (b) inside
        CMD_BAUD, CMD_LOAD_ADDR, CMD_WRITE, CMD_BURST_WRITE, CMD_FLASH, CMD_BURST_FLASH,
        CMD_HW_WRITE: begin
          phase_next = PH_OPER;
        end
        CMD_READ, CMD_BURST_READ: begin
          emit       = 1'b1;
          job.kind   = JOB_READ;
          ptr_next   = ptr + 32'd1;
          phase_next = PH_RDATA;
        end
        CMD_HW_READ: begin
          emit       = 1'b1;
          job.kind   = JOB_READ;
          job.hw     = 1'b1;
          ptr_next   = ptr + 32'd2;
          phase_next = PH_RDATA;
        end
        CMD_EXEC: begin
          emit     = 1'b1;
          job.kind = JOB_EXEC;
        end
        CMD_VERSION: begin
          emit     = 1'b1;
          job.kind = JOB_TX;
          job.tx   = VERSION_ID;
        end
        default: begin
          led_next = 1'b1;
          emit     = 1'b1;
          job.kind = JOB_TX;
          job.tx   = ~b;
        end
      endcase
    end else if (in_word.func == FUNC_RX && phase == PH_OPER) begin
      job.data = {8'h00, b};
      job.echo = 1'b1;
      unique case (cmd) inside
        CMD_BAUD: begin
          emit     = 1'b1;
          job.kind = JOB_BAUD;
          job.tx   = b;
        end
        CMD_LOAD_ADDR: begin
          if (cnt < 5'd3) begin
            shift_next = {shift[15:0], b};
            cnt_next   = cnt_inc;
            done       = 1'b0;
          end else begin
            ptr_next   = {shift, b};
            fbase_next = {shift, b} & FLASH_MASK;
            emit       = 1'b1;
            job.kind   = JOB_TX;
            job.tx     = cmd;
          end
        end
        CMD_WRITE: begin
          emit     = 1'b1;
          job.kind = JOB_WRITE;
          ptr_next = ptr + 32'd1;
        end
        CMD_BURST_WRITE, CMD_BURST_FLASH: begin
          emit     = 1'b1;
          job.kind = (cmd == CMD_BURST_WRITE) ? JOB_WRITE : JOB_FLASH;
          ptr_next = ptr + 32'd1;
          job.echo = (cnt_inc >= BURST_LEN);
          if (cnt_inc < BURST_LEN) begin
            cnt_next = cnt_inc;
            done     = 1'b0;
          end
        end
        CMD_FLASH: begin
          emit     = 1'b1;
          job.kind = JOB_FLASH;
          ptr_next = ptr + 32'd1;
        end
        CMD_HW_WRITE: begin
          if (cnt == 5'd0) begin
            shift_next = {16'h0000, b};
            cnt_next   = 5'd1;
            done       = 1'b0;
          end else begin
            emit     = 1'b1;
            job.kind = JOB_WRITE;
            job.hw   = 1'b1;
            job.data = {shift[7:0], b};
            ptr_next = ptr + 32'd2;
          end
        end
        default: begin
        end
      endcase
      if (done) begin
        phase_next = PH_IDLE;
        cnt_next   = '0;
      end
    end else if (in_word.func == FUNC_RDATA && phase == PH_RDATA) begin
      phase_next = PH_IDLE;
      emit       = 1'b1;
      job.kind   = JOB_TX;
      job.tx     = d[7:0];
      if (cmd == CMD_HW_READ) begin
        job.kind = JOB_TX2;
        job.tx   = d[15:8];
        job.code = d[7:0];
      end else if (cmd == CMD_BURST_READ) begin
        if (cnt_inc < BURST_LEN) begin
          job.kind   = JOB_TXREAD;
          ptr_next   = ptr + 32'd1;
          phase_next = PH_RDATA;
          cnt_next   = cnt_inc;
        end else begin
          cnt_next = '0;
        end
      end
    end
    job.led = led_next;
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cmd   <= '0;
      cnt   <= '0;
      shift <= '0;
      ptr   <= '0;
      fbase <= '0;
      led   <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      cmd   <= cmd_next;
      cnt   <= cnt_next;
      shift <= shift_next;
      ptr   <= ptr_next;
      fbase <= fbase_next;
      led   <= led_next;
    end
  end

endmodule

// ===== rtl/umm_job_fifo.sv =====
// Short job queue between the parser and the result sequencer.
// Depends on umm_pkg.
module umm_job_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  umm_pkg::job_t      push_job,
  input  logic               pop,
  output umm_pkg::job_t      head,
  output umm_pkg::q_status_t q_status
);
  import umm_pkg::*;

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign q_status.full      = (count == QCNT_W'(QDEPTH));
  assign q_status.not_empty = (count != '0);
  assign do_push            = push && !q_status.full;
  assign do_pop             = pop && q_status.not_empty;
  assign head               = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= QPTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= QPTR_W'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= QCNT_W'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= QCNT_W'(count - 1'b1);
      end
    end
  end

endmodule

// ===== rtl/umm_back.sv =====
// Result sequencer: expands the job at the queue head into result words, one per
// cycle while the output is not stalled, through a registered output stage. Depends on umm_pkg.
module umm_back (
  input  logic               clk,
  input  logic               rst,
  input  umm_pkg::job_t      head,
  input  umm_pkg::q_status_t q_status,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output umm_pkg::out_word_t out_word
);
  import umm_pkg::*;

  logic [2:0] step;
  out_word_t  res;
  logic       fin;
  logic       load;

  always_comb begin
    res        = '0;
    res.led_on = head.led;
    fin        = 1'b1;
    unique case (head.kind)
      JOB_TX: begin
        res.tx_byte = head.tx;
      end
      JOB_TX2: begin
        if (step == 3'd0) begin
          res.tx_byte = head.tx;
          fin         = 1'b0;
        end else begin
          res.tx_byte = head.code;
        end
      end
      JOB_READ: begin
        res.action      = ACT_READ;
        res.bus_address = head.addr;
        res.halfword    = head.hw;
      end
      JOB_TXREAD: begin
        if (step == 3'd0) begin
          res.tx_byte = head.tx;
          fin         = 1'b0;
        end else begin
          res.action      = ACT_READ;
          res.bus_address = head.addr;
        end
      end
      JOB_WRITE: begin
        if (step == 3'd0) begin
          res.action      = ACT_WRITE;
          res.bus_address = head.addr;
          res.bus_data    = head.data;
          res.halfword    = head.hw;
          fin             = !head.echo;
        end else begin
          res.tx_byte = head.code;
        end
      end
      JOB_BAUD: begin
        if (step == 3'd0) begin
          res.tx_byte = head.code;
          fin         = 1'b0;
        end else begin
          res.action  = ACT_BAUD;
          res.tx_byte = head.tx;
        end
      end
      JOB_EXEC: begin
        if (step == 3'd0) begin
          res.action      = ACT_EXEC;
          res.bus_address = head.addr;
          fin             = 1'b0;
        end else begin
          res.tx_byte = head.code;
        end
      end
      JOB_FLASH: begin
        case (step)
          3'd0: begin
            res.action      = ACT_WRITE;
            res.bus_address = head.fbase + FLASH_ADDR_A;
            res.bus_data    = FLASH_DATA_1;
            fin             = 1'b0;
          end
          3'd1: begin
            res.action      = ACT_WRITE;
            res.bus_address = head.fbase + FLASH_ADDR_B;
            res.bus_data    = FLASH_DATA_2;
            fin             = 1'b0;
          end
          3'd2: begin
            res.action      = ACT_WRITE;
            res.bus_address = head.fbase + FLASH_ADDR_A;
            res.bus_data    = FLASH_DATA_3;
            fin             = 1'b0;
          end
          3'd3: begin
            res.action      = ACT_WRITE;
            res.bus_address = head.addr;
            res.bus_data    = head.data;
            fin             = !head.echo;
          end
          default: begin
            res.tx_byte = head.code;
          end
        endcase
      end
      default: begin
      end
    endcase
    res.last = fin;
  end

  assign load = q_status.not_empty && (!out_valid || !out_stall);
  assign pop  = load && fin;

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= fin ? 3'd0 : 3'(step + 3'd1);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/umm_checker.sv =====
// Port-level checks for the serial monitor bus bridge, bound to the top level.
// Depends on umm_pkg and uart_memory_monitor_bridge.
module umm_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input umm_pkg::out_word_t out_word
);
  import umm_pkg::*;

  logic led_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      led_seen <= 1'b0;
    end else if (out_valid && !out_stall && out_word.led_on) begin
      led_seen <= 1'b1;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  a_led_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && led_seen |-> out_word.led_on)
    else $error("error LED went dark");

  a_tx_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_word.action == ACT_TX || out_word.action == ACT_BAUD) |->
      out_word.bus_address == '0 && out_word.bus_data == '0 && !out_word.halfword)
    else $error("transmit word carries bus fields");

  a_action_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.action <= ACT_EXEC)
    else $error("action code out of range");

endmodule

bind uart_memory_monitor_bridge umm_checker u_umm_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

// ===== bench/uart_memory_monitor_bridge_checker.sv =====
// Result checker for the serial monitor bus bridge: watches both channels, predicts the
// result words of each accepted input word and compares them in order.
// Depends on umm_pkg.
module uart_memory_monitor_bridge_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  umm_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  umm_pkg::out_word_t out_word,
  output int                 errors,
  output int                 pending,
  output int                 words_in,
  output int                 words_out,
  output int                 held_cycles
);
  import umm_pkg::*;

  localparam logic [31:0] UNLOCK_ADDR_A = 32'h0000_5555;
  localparam logic [31:0] UNLOCK_ADDR_B = 32'h0000_2AAA;
  localparam logic [15:0] UNLOCK_DATA_1 = 16'h00AA;
  localparam logic [15:0] UNLOCK_DATA_2 = 16'h0055;
  localparam logic [15:0] UNLOCK_DATA_3 = 16'h00A0;
  localparam int          MAX_PRINTED   = 100;

  logic [1:0]  phase;
  logic [7:0]  cur_cmd;
  logic [4:0]  op_cnt;
  logic [23:0] asm_reg;
  logic [31:0] addr_ptr;
  logic [31:0] unlock_base;
  logic        led_lit;

  out_word_t expected_words[$];

  task automatic push_result(input logic [2:0] act, input logic [7:0] tx,
                             input logic [31:0] addr, input logic [15:0] data,
                             input logic hw);
    out_word_t r;
    r.action      = act;
    r.tx_byte     = tx;
    r.bus_address = addr;
    r.bus_data    = data;
    r.halfword    = hw;
    r.led_on      = led_lit;
    r.last        = 1'b0;
    expected_words.push_back(r);
  endtask

  task automatic program_flash(input logic [7:0] b);
    push_result(ACT_WRITE, 8'h00, unlock_base + UNLOCK_ADDR_A, UNLOCK_DATA_1, 1'b0);
    push_result(ACT_WRITE, 8'h00, unlock_base + UNLOCK_ADDR_B, UNLOCK_DATA_2, 1'b0);
    push_result(ACT_WRITE, 8'h00, unlock_base + UNLOCK_ADDR_A, UNLOCK_DATA_3, 1'b0);
    push_result(ACT_WRITE, 8'h00, addr_ptr, {8'h00, b}, 1'b0);
    addr_ptr = addr_ptr + 32'd1;
  endtask

  task automatic take_command(input logic [7:0] c);
    cur_cmd = c;
    op_cnt  = '0;
    asm_reg = '0;
    phase   = PH_IDLE;
    case (c)
      CMD_BAUD, CMD_LOAD_ADDR, CMD_WRITE, CMD_BURST_WRITE, CMD_FLASH, CMD_BURST_FLASH,
      CMD_HW_WRITE: phase = PH_OPER;
      CMD_READ, CMD_BURST_READ: begin
        push_result(ACT_READ, 8'h00, addr_ptr, 16'h0000, 1'b0);
        addr_ptr = addr_ptr + 32'd1;
        phase = PH_RDATA;
      end
      CMD_HW_READ: begin
        push_result(ACT_READ, 8'h00, addr_ptr, 16'h0000, 1'b1);
        addr_ptr = addr_ptr + 32'd2;
        phase = PH_RDATA;
      end
      CMD_EXEC: begin
        push_result(ACT_EXEC, 8'h00, addr_ptr, 16'h0000, 1'b0);
        push_result(ACT_TX, c, 32'h0, 16'h0000, 1'b0);
      end
      CMD_VERSION: push_result(ACT_TX, VERSION_ID, 32'h0, 16'h0000, 1'b0);
      default: begin
        led_lit = 1'b1;
        push_result(ACT_TX, ~c, 32'h0, 16'h0000, 1'b0);
      end
    endcase
  endtask

  task automatic take_operand(input logic [7:0] b);
    logic done;
    done = 1'b1;
    case (cur_cmd)
      CMD_BAUD: begin
        push_result(ACT_TX, cur_cmd, 32'h0, 16'h0000, 1'b0);
        push_result(ACT_BAUD, b, 32'h0, 16'h0000, 1'b0);
      end
      CMD_LOAD_ADDR: begin
        if (op_cnt < 5'd3) begin
          asm_reg = {asm_reg[15:0], b};
          op_cnt  = op_cnt + 5'd1;
          done    = 1'b0;
        end else begin
          addr_ptr    = {asm_reg, b};
          unlock_base = addr_ptr & ~((32'd1 << FLASH_ALIGN_BITS) - 32'd1);
          push_result(ACT_TX, cur_cmd, 32'h0, 16'h0000, 1'b0);
        end
      end
      CMD_WRITE: begin
        push_result(ACT_WRITE, 8'h00, addr_ptr, {8'h00, b}, 1'b0);
        addr_ptr = addr_ptr + 32'd1;
        push_result(ACT_TX, cur_cmd, 32'h0, 16'h0000, 1'b0);
      end
      CMD_BURST_WRITE, CMD_BURST_FLASH: begin
        if (cur_cmd == CMD_BURST_WRITE) begin
          push_result(ACT_WRITE, 8'h00, addr_ptr, {8'h00, b}, 1'b0);
          addr_ptr = addr_ptr + 32'd1;
        end else begin
          program_flash(b);
        end
        op_cnt = op_cnt + 5'd1;
        if (op_cnt >= BURST_LENGTH) push_result(ACT_TX, cur_cmd, 32'h0, 16'h0000, 1'b0);
        else done = 1'b0;
      end
      CMD_FLASH: begin
        program_flash(b);
        push_result(ACT_TX, cur_cmd, 32'h0, 16'h0000, 1'b0);
      end
      CMD_HW_WRITE: begin
        if (op_cnt == 5'd0) begin
          asm_reg = {16'h0000, b};
          op_cnt  = 5'd1;
          done    = 1'b0;
        end else begin
          push_result(ACT_WRITE, 8'h00, addr_ptr, {asm_reg[7:0], b}, 1'b1);
          addr_ptr = addr_ptr + 32'd2;
          push_result(ACT_TX, cur_cmd, 32'h0, 16'h0000, 1'b0);
        end
      end
      default: ;
    endcase
    if (done) begin
      phase  = PH_IDLE;
      op_cnt = '0;
    end
  endtask

  task automatic take_read_data(input logic [15:0] d);
    phase = PH_IDLE;
    if (cur_cmd == CMD_HW_READ) begin
      push_result(ACT_TX, d[15:8], 32'h0, 16'h0000, 1'b0);
      push_result(ACT_TX, d[7:0], 32'h0, 16'h0000, 1'b0);
    end else if (cur_cmd == CMD_BURST_READ) begin
      push_result(ACT_TX, d[7:0], 32'h0, 16'h0000, 1'b0);
      op_cnt = op_cnt + 5'd1;
      if (op_cnt < BURST_LENGTH) begin
        push_result(ACT_READ, 8'h00, addr_ptr, 16'h0000, 1'b0);
        addr_ptr = addr_ptr + 32'd1;
        phase = PH_RDATA;
      end else begin
        op_cnt = '0;
      end
    end else begin
      push_result(ACT_TX, d[7:0], 32'h0, 16'h0000, 1'b0);
    end
  endtask

  task automatic predict_word(input in_word_t w);
    int        size_prior;
    out_word_t tail;
    size_prior = expected_words.size();
    if (w.func == FUNC_RX) begin
      if (phase == PH_IDLE) take_command(w.rx_byte);
      else if (phase == PH_OPER) take_operand(w.rx_byte);
    end else if (phase == PH_RDATA) begin
      take_read_data(w.read_data);
    end
    if (expected_words.size() > size_prior) begin
      tail = expected_words.pop_back();
      tail.last = 1'b1;
      expected_words.push_back(tail);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("checker: %s mismatch on result %0d: got %0h, expected %0h",
               what, words_out, got, want);
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("unexpected word", {29'd0, got.action}, 32'd0);
    end else begin
      want = expected_words.pop_front();
      if (got.action !== want.action)
        report_mismatch("action", {29'd0, got.action}, {29'd0, want.action});
      if (got.tx_byte !== want.tx_byte)
        report_mismatch("tx_byte", {24'd0, got.tx_byte}, {24'd0, want.tx_byte});
      if (got.bus_address !== want.bus_address)
        report_mismatch("bus_address", got.bus_address, want.bus_address);
      if (got.bus_data !== want.bus_data)
        report_mismatch("bus_data", {16'd0, got.bus_data}, {16'd0, want.bus_data});
      if (got.halfword !== want.halfword)
        report_mismatch("halfword", {31'd0, got.halfword}, {31'd0, want.halfword});
      if (got.led_on !== want.led_on)
        report_mismatch("led_on", {31'd0, got.led_on}, {31'd0, want.led_on});
      if (got.last !== want.last)
        report_mismatch("last", {31'd0, got.last}, {31'd0, want.last});
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase       = PH_IDLE;
      cur_cmd     = '0;
      op_cnt      = '0;
      asm_reg     = '0;
      addr_ptr    = '0;
      unlock_base = '0;
      led_lit     = 1'b0;
      errors      = 0;
      words_in    = 0;
      words_out   = 0;
      held_cycles = 0;
      expected_words.delete();
    end else begin
      if (in_valid && in_stall) held_cycles++;
      if (in_valid && !in_stall) begin
        predict_word(in_word);
        words_in++;
      end
      if (out_valid && !out_stall) begin
        check_result(out_word);
        words_out++;
      end
    end
    pending = expected_words.size();
  end

endmodule

// ===== bench/uart_memory_monitor_bridge_test.sv =====
// Testbench top for the serial monitor bus bridge: clock, reset, command stimulus and
// random flow control on both channels; the verdict comes from the checker's counts.
// Depends on umm_pkg, uart_memory_monitor_bridge, uart_memory_monitor_bridge_checker.
module uart_memory_monitor_bridge_test;
  import umm_pkg::*;

  localparam int          LIMIT_CYCLES  = 400000;
  localparam int          RANDOM_WORDS  = 70;
  localparam int          LONG_HOLD     = 300;
  localparam int          DRAIN_CYCLES  = 24;
  localparam logic [7:0]  FIRST_UNKNOWN = CMD_VERSION + 8'd1;
  localparam logic [7:0]  LAST_UNKNOWN  = 8'hFF;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  int errors, pending, words_in, words_out, held_cycles;
  int sent;
  int cycles;
  bit steady;
  bit hold_request;

  uart_memory_monitor_bridge u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  uart_memory_monitor_bridge_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .errors      (errors),
    .pending     (pending),
    .words_in    (words_in),
    .words_out   (words_out),
    .held_cycles (held_cycles)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("uart_memory_monitor_bridge_test: FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // receiver flow control
  initial begin
    int stall_run, free_run;
    bit hold_done;
    stall_run = 0;
    free_run  = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        stall_run = LONG_HOLD;
        free_run  = 0;
      end else if (stall_run == 0 && free_run == 0) begin
        free_run  = $urandom_range(1, 8);
        stall_run = pick_gap();
      end
      if (stall_run > 0) begin
        out_stall = 1'b1;
        stall_run--;
      end else begin
        out_stall = 1'b0;
        free_run--;
      end
    end
  end

  function automatic in_word_t rx_word(input logic [7:0] b);
    in_word_t w;
    w.func      = FUNC_RX;
    w.rx_byte   = b;
    w.read_data = 16'($urandom);
    return w;
  endfunction

  function automatic in_word_t rdata_word(input logic [15:0] d);
    in_word_t w;
    w.func      = FUNC_RDATA;
    w.rx_byte   = 8'($urandom);
    w.read_data = d;
    return w;
  endfunction

  function automatic logic [31:0] pick_address();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 7) return {16'h0000, 16'($urandom)};
    if (r < 9) return {28'hFFFF_FFF, 4'($urandom)};
    return {13'($urandom), 19'h0_0000};
  endfunction

  task automatic send_word(input in_word_t w, input bit counted);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_word  = w;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (counted) sent++;
  endtask

  task automatic load_address(input logic [31:0] a);
    send_word(rx_word(CMD_LOAD_ADDR), 1'b1);
    send_word(rx_word(a[31:24]), 1'b1);
    send_word(rx_word(a[23:16]), 1'b1);
    send_word(rx_word(a[15:8]), 1'b1);
    send_word(rx_word(a[7:0]), 1'b1);
  endtask

  task automatic burst(input logic [7:0] cmd);
    send_word(rx_word(cmd), 1'b1);
    for (int i = 0; i < BURST_LENGTH; i++) begin
      if (cmd == CMD_BURST_READ) begin
        if ($urandom_range(0, 7) == 0) send_word(rx_word(8'($urandom)), 1'b0);
        send_word(rdata_word(16'($urandom)), 1'b1);
      end else begin
        send_word(rx_word(8'($urandom)), 1'b1);
      end
    end
  endtask

  task automatic random_sequence();
    int k;
    int n;
    k = $urandom_range(0, 99);
    if (k < 8) begin
      send_word(rx_word(CMD_BAUD), 1'b1);
      send_word(rx_word(8'($urandom)), 1'b1);
    end else if (k < 20) begin
      load_address(pick_address());
    end else if (k < 28) begin
      send_word(rx_word(CMD_READ), 1'b1);
      if ($urandom_range(0, 3) == 0) send_word(rx_word(8'($urandom)), 1'b0);
      send_word(rdata_word(16'($urandom)), 1'b1);
    end else if (k < 38) begin
      send_word(rx_word(CMD_WRITE), 1'b1);
      send_word(rx_word(8'($urandom)), 1'b1);
    end else if (k < 41) begin
      burst(CMD_BURST_WRITE);
    end else if (k < 44) begin
      burst(CMD_BURST_READ);
    end else if (k < 47) begin
      burst(CMD_BURST_FLASH);
    end else if (k < 55) begin
      send_word(rx_word(CMD_FLASH), 1'b1);
      send_word(rx_word(8'($urandom)), 1'b1);
    end else if (k < 63) begin
      send_word(rx_word(CMD_HW_READ), 1'b1);
      send_word(rdata_word(16'($urandom)), 1'b1);
    end else if (k < 73) begin
      send_word(rx_word(CMD_HW_WRITE), 1'b1);
      send_word(rx_word(8'($urandom)), 1'b1);
      send_word(rx_word(8'($urandom)), 1'b1);
    end else if (k < 78) begin
      send_word(rx_word(CMD_EXEC), 1'b1);
    end else if (k < 82) begin
      send_word(rx_word(CMD_VERSION), 1'b1);
    end else if (k < 86) begin
      send_word(rx_word(8'($urandom_range(FIRST_UNKNOWN, LAST_UNKNOWN))), 1'b1);
    end else if (k < 92) begin
      send_word(rdata_word(16'($urandom)), 1'b0);
    end else begin
      // truncated command: the next bytes land as its operands
      case ($urandom_range(0, 2))
        0:       send_word(rx_word(CMD_LOAD_ADDR), 1'b1);
        1:       send_word(rx_word(CMD_HW_WRITE), 1'b1);
        default: send_word(rx_word(CMD_BURST_WRITE), 1'b1);
      endcase
      n = $urandom_range(0, 2);
      repeat (n) send_word(rx_word(8'($urandom)), 1'b1);
    end
  endtask

  initial begin
    int base;
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_word      = '0;
    steady       = 1'b0;
    hold_request = 1'b0;
    sent         = 0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    send_word(rx_word(CMD_VERSION), 1'b1);
    send_word(rx_word(CMD_EXEC), 1'b1);
    send_word(rx_word(CMD_READ), 1'b1);
    send_word(rdata_word(16'hFFFF), 1'b1);
    send_word(rdata_word(16'h1234), 1'b0);
    load_address(32'hFFFF_FFFF);
    send_word(rx_word(CMD_HW_WRITE), 1'b1);
    send_word(rx_word(8'hAB), 1'b1);
    send_word(rx_word(8'hCD), 1'b1);
    send_word(rx_word(CMD_WRITE), 1'b1);
    send_word(rx_word(8'h00), 1'b1);
    send_word(rx_word(CMD_HW_READ), 1'b1);
    send_word(rx_word(8'h55), 1'b0);
    send_word(rdata_word(16'hA55A), 1'b1);
    send_word(rx_word(CMD_FLASH), 1'b1);
    send_word(rx_word(8'h80), 1'b1);
    send_word(rx_word(CMD_BAUD), 1'b1);
    send_word(rx_word(8'hFF), 1'b1);
    send_word(rx_word(CMD_BAUD), 1'b1);
    send_word(rx_word(8'h00), 1'b1);
    send_word(rx_word(LAST_UNKNOWN), 1'b1);
    send_word(rx_word(FIRST_UNKNOWN), 1'b1);

    // long receiver hold while a flash burst streams in back to back
    hold_request = 1'b1;
    steady       = 1'b1;
    burst(CMD_BURST_FLASH);
    steady = 1'b0;
    burst(CMD_BURST_READ);

    base = sent;
    while (sent < base + RANDOM_WORDS) begin
      steady = ($urandom_range(0, 9) == 0);
      random_sequence();
    end
    steady = 1'b0;
    @(negedge clk);
    in_valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d input words, %0d result words checked, input held off %0d cycles",
             words_in, words_out, held_cycles);
    $display("all command codes, unknown codes, bursts, address wrap and ignored words sent");
    if (errors == 0 && pending == 0)
      $display("uart_memory_monitor_bridge_test: PASS");
    else
      $display("uart_memory_monitor_bridge_test: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/umm_pkg.sv
rtl/umm_front.sv
rtl/umm_job_fifo.sv
rtl/umm_back.sv
rtl/uart_memory_monitor_bridge.sv
rtl/umm_checker.sv
bench/uart_memory_monitor_bridge_checker.sv
bench/uart_memory_monitor_bridge_test.sv
